// ===== sv/vgr_pkg.sv =====
// Shared types, constants and codes for the vertical gradient raster generator.
package vgr_pkg;

  localparam int MAX_SEGMENTS = 8;
  localparam int MAX_SIDE     = 4096;

  localparam int SEG_IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int POS_W      = $clog2(MAX_SIDE);
  localparam int NUM_W      = POS_W + 8;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int RATIO_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [RATIO_W-1:0] RATIO_ONE   = RATIO_W'(65536);
  localparam logic [31:0]        COLOR_BLACK = 32'h0000_00FF;
  localparam logic [SIDE_W-1:0]  SIDE_RESET  = SIDE_W'(256);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [2:0]  seg_index;
    logic [16:0] start_ratio;
    logic [16:0] end_ratio;
    logic [31:0] start_rgba;
    logic [31:0] end_rgba;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       line_end;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic                 load;
    logic                 emit;
    logic                 span;
    logic                 start_blend;
    logic                 ch_start;
    logic                 div_step;
    logic                 ch_finish;
    logic                 set_black;
    logic [SEG_IDX_W-1:0] seg_sel;
    logic [1:0]           ch_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic             hit;
    logic             zero_len;
    logic             out_free;
    logic             last_col;
    logic [CNT_W-1:0] seg_count;
  } dp_stat_t;

endpackage

// ===== sv/vgr_dp.sv =====
// Datapath: config registers, segment table, position counters, span and blend units, output register.
module vgr_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  vgr_pkg::in_item_t               in_item,
  input  logic                            cfg_write,
  input  logic [vgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vgr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  vgr_pkg::dp_cmd_t                cmd,
  output vgr_pkg::dp_stat_t               stat,
  input  logic                            out_ready,
  output logic                            out_valid,
  output vgr_pkg::out_item_t              out_item
);

  logic [vgr_pkg::SIDE_W-1:0]  frame_width;
  logic [vgr_pkg::SIDE_W-1:0]  frame_height;
  logic [vgr_pkg::CNT_W-1:0]   segment_count;
  logic [vgr_pkg::POS_W-1:0]   column_count;
  logic [vgr_pkg::POS_W-1:0]   row_count;

  logic [vgr_pkg::RATIO_W-1:0] seg_start_ratio [vgr_pkg::MAX_SEGMENTS];
  logic [vgr_pkg::RATIO_W-1:0] seg_end_ratio   [vgr_pkg::MAX_SEGMENTS];
  logic [31:0]                 seg_start_color [vgr_pkg::MAX_SEGMENTS];
  logic [31:0]                 seg_end_color   [vgr_pkg::MAX_SEGMENTS];

  logic [vgr_pkg::SIDE_W-1:0]  sp;
  logic [vgr_pkg::SIDE_W-1:0]  ep;
  logic [31:0]                 c0;
  logic [31:0]                 c1;
  logic [vgr_pkg::POS_W-1:0]   off;
  logic [vgr_pkg::SIDE_W-1:0]  len;
  logic [31:0]                 color;
  logic [vgr_pkg::NUM_W-1:0]   dvd;
  logic [vgr_pkg::SIDE_W-1:0]  rem;
  logic                        neg;

  logic [vgr_pkg::SEG_IDX_W-1:0]        wr_addr;
  logic [vgr_pkg::RATIO_W-1:0]          r0_sat;
  logic [vgr_pkg::RATIO_W-1:0]          r1_sat;
  logic [vgr_pkg::RATIO_W+vgr_pkg::SIDE_W-1:0] sp_prod;
  logic [vgr_pkg::RATIO_W+vgr_pkg::SIDE_W-1:0] ep_prod;
  logic [vgr_pkg::SIDE_W-1:0]           row_ext;
  logic [7:0]                           ch_a;
  logic [7:0]                           ch_b;
  logic [7:0]                           ch_mag;
  logic [vgr_pkg::SIDE_W:0]             trial;
  logic                                 qbit;
  logic [7:0]                           quot;
  logic [7:0]                           ch_res;
  logic                                 last_col;
  logic                                 last_row;
  logic [vgr_pkg::SIDE_W-1:0]           side_val;
  logic [vgr_pkg::CNT_W-1:0]            count_val;

  assign wr_addr = vgr_pkg::SEG_IDX_W'(in_item.seg_index);
  assign r0_sat  = (in_item.start_ratio > vgr_pkg::RATIO_ONE) ? vgr_pkg::RATIO_ONE
                                                              : in_item.start_ratio;
  assign r1_sat  = (in_item.end_ratio > vgr_pkg::RATIO_ONE) ? vgr_pkg::RATIO_ONE
                                                            : in_item.end_ratio;

  assign sp_prod = seg_start_ratio[cmd.seg_sel] * frame_height;
  assign ep_prod = seg_end_ratio[cmd.seg_sel] * frame_height;
  assign row_ext = vgr_pkg::SIDE_W'(row_count);

  assign ch_a   = c0[cmd.ch_sel*8 +: 8];
  assign ch_b   = c1[cmd.ch_sel*8 +: 8];
  assign ch_mag = (ch_b < ch_a) ? (ch_a - ch_b) : (ch_b - ch_a);

  assign trial = {rem, dvd[vgr_pkg::NUM_W-1]};
  assign qbit  = (trial >= {1'b0, len});

  // floor division: a negative quotient with a remainder rounds down one more
  assign quot   = dvd[7:0];
  assign ch_res = neg ? (ch_a - quot - 8'((rem != '0) ? 1 : 0)) : (ch_a + quot);

  assign last_col = (32'(column_count) + 1) >= 32'(frame_width);
  assign last_row = (32'(row_count) + 1) >= 32'(frame_height);

  always_comb begin
    if (32'(cfg_data) < 1) begin
      side_val = vgr_pkg::SIDE_W'(1);
    end else if (32'(cfg_data) > vgr_pkg::MAX_SIDE) begin
      side_val = vgr_pkg::SIDE_W'(vgr_pkg::MAX_SIDE);
    end else begin
      side_val = vgr_pkg::SIDE_W'(cfg_data);
    end
    if (32'(cfg_data[3:0]) > vgr_pkg::MAX_SEGMENTS) begin
      count_val = vgr_pkg::CNT_W'(vgr_pkg::MAX_SEGMENTS);
    end else begin
      count_val = vgr_pkg::CNT_W'(cfg_data[3:0]);
    end
  end

  assign stat.hit       = (row_ext >= sp) && (row_ext <= ep);
  assign stat.zero_len  = (ep == sp);
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.last_col  = last_col;
  assign stat.seg_count = segment_count;

  // segment table, no reset
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(in_item.seg_index) < vgr_pkg::MAX_SEGMENTS)) begin
      seg_start_ratio[wr_addr] <= r0_sat;
      seg_end_ratio[wr_addr]   <= r1_sat;
      seg_start_color[wr_addr] <= in_item.start_rgba;
      seg_end_color[wr_addr]   <= in_item.end_rgba;
    end
  end

  // span and blend working registers
  always_ff @(posedge clk) begin
    if (cmd.span) begin
      sp <= vgr_pkg::SIDE_W'(sp_prod >> 16);
      ep <= vgr_pkg::SIDE_W'(ep_prod >> 16);
      c0 <= seg_start_color[cmd.seg_sel];
      c1 <= seg_end_color[cmd.seg_sel];
    end
    if (cmd.start_blend) begin
      off   <= vgr_pkg::POS_W'(row_ext - sp);
      len   <= ep - sp;
      color <= c0;
    end
    if (cmd.set_black) begin
      color <= vgr_pkg::COLOR_BLACK;
    end
    if (cmd.ch_start) begin
      dvd <= vgr_pkg::NUM_W'(off * ch_mag);
      rem <= '0;
      neg <= (ch_b < ch_a);
    end
    if (cmd.div_step) begin
      rem <= qbit ? vgr_pkg::SIDE_W'(trial - {1'b0, len}) : trial[vgr_pkg::SIDE_W-1:0];
      dvd <= {dvd[vgr_pkg::NUM_W-2:0], qbit};
    end
    if (cmd.ch_finish) begin
      color[cmd.ch_sel*8 +: 8] <= ch_res;
    end
  end

  // config, position and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= vgr_pkg::SIDE_RESET;
      frame_height  <= vgr_pkg::SIDE_RESET;
      segment_count <= '0;
      column_count  <= '0;
      row_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          vgr_pkg::CFG_FRAME_WIDTH:   frame_width   <= side_val;
          vgr_pkg::CFG_FRAME_HEIGHT:  frame_height  <= side_val;
          vgr_pkg::CFG_SEGMENT_COUNT: segment_count <= count_val;
          default: ;
        endcase
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.red       <= color[31:24];
      out_item.green     <= color[23:16];
      out_item.blue      <= color[15:8];
      out_item.alpha     <= color[7:0];
      out_item.line_end  <= last_col;
      out_item.frame_end <= last_col && last_row;
    end
  end

endmodule

// ===== sv/vgr_ctrl.sv =====
// Controller: item acceptance, segment search, per-channel divide sequencing, row color cache.
module vgr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_mode,
  output logic               in_ready,
  input  logic               cfg_write,
  input  vgr_pkg::dp_stat_t  stat,
  output vgr_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SPAN,
    TEST,
    CH_START,
    DIV,
    CH_DONE,
    EMIT
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [vgr_pkg::SEG_IDX_W-1:0] seg_idx;
  logic [vgr_pkg::SEG_IDX_W-1:0] seg_idx_next;
  logic [1:0]                    ch;
  logic [1:0]                    ch_next;
  logic [vgr_pkg::STEP_W-1:0]    step;
  logic [vgr_pkg::STEP_W-1:0]    step_next;
  logic                          cache_valid;
  logic                          cache_valid_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next       = state;
    seg_idx_next     = seg_idx;
    ch_next          = ch;
    step_next        = step;
    cache_valid_next = cache_valid;
    cmd              = '0;
    cmd.seg_sel      = seg_idx;
    cmd.ch_sel       = ch;
    case (state)
      IDLE: begin
        if (in_valid) begin
          if (in_mode == vgr_pkg::MODE_LOAD) begin
            cmd.load         = 1'b1;
            cache_valid_next = 1'b0;
          end else if (cache_valid && stat.out_free) begin
            cmd.emit = 1'b1;
            if (stat.last_col) begin
              cache_valid_next = 1'b0;
            end
          end else if (cache_valid) begin
            state_next = EMIT;
          end else if (stat.seg_count == '0) begin
            cmd.set_black    = 1'b1;
            cache_valid_next = 1'b1;
            state_next       = EMIT;
          end else begin
            seg_idx_next = '0;
            state_next   = SPAN;
          end
        end
      end
      SPAN: begin
        cmd.span   = 1'b1;
        state_next = TEST;
      end
      TEST: begin
        if (stat.hit) begin
          cmd.start_blend = 1'b1;
          if (stat.zero_len) begin
            cache_valid_next = 1'b1;
            state_next       = EMIT;
          end else begin
            ch_next    = 2'd0;
            state_next = CH_START;
          end
        end else if ((32'(seg_idx) + 1) >= 32'(stat.seg_count)) begin
          cmd.set_black    = 1'b1;
          cache_valid_next = 1'b1;
          state_next       = EMIT;
        end else begin
          seg_idx_next = seg_idx + 1'b1;
          state_next   = SPAN;
        end
      end
      CH_START: begin
        cmd.ch_start = 1'b1;
        step_next    = '0;
        state_next   = DIV;
      end
      DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == vgr_pkg::STEP_W'(vgr_pkg::NUM_W - 1)) begin
          state_next = CH_DONE;
        end
      end
      CH_DONE: begin
        cmd.ch_finish = 1'b1;
        if (ch == 2'd3) begin
          cache_valid_next = 1'b1;
          state_next       = EMIT;
        end else begin
          ch_next    = ch + 2'd1;
          state_next = CH_START;
        end
      end
      EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
          if (stat.last_col) begin
            cache_valid_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
    if (cfg_write) begin
      cache_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      seg_idx     <= '0;
      ch          <= '0;
      step        <= '0;
      cache_valid <= 1'b0;
    end else begin
      state       <= state_next;
      seg_idx     <= seg_idx_next;
      ch          <= ch_next;
      step        <= step_next;
      cache_valid <= cache_valid_next;
    end
  end

endmodule

// ===== sv/vertical_gradient_raster_generator.sv =====
// Top level of the vertical gradient raster generator.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid / in_ready         in_item (load entry or pixel request)
//   out      output     out_valid / out_ready       out_item (RGBA, line_end, frame_end)
//   cfg      input      cfg_write                   cfg_index, cfg_data
//
// A pixel item whose row color is cached is emitted from the cache; the color is cached per row.
// The first pixel of a row searches the segments in turn, SPAN then TEST for each,
// then runs a restoring divider over the NUM_W (20)-bit dividend for each channel.
// Loads, config writes and row changes drop the cache.
// Reset is synchronous; the output register holds a result until out_ready.
module vertical_gradient_raster_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vgr_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vgr_pkg::out_item_t              out_item,
  input  logic                            cfg_write,
  input  logic [vgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vgr_pkg::dp_cmd_t  cmd;
  vgr_pkg::dp_stat_t stat;

  vgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (in_item.mode),
    .in_ready  (in_ready),
    .cfg_write (cfg_write),
    .stat      (stat),
    .cmd       (cmd)
  );

  vgr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
